[rtl/core/lla_pkg.sv]
package lla_pkg;

    // sizes fixed by the item fields
    localparam int NUM_SLOTS_DEF = 4;
    localparam int KIND_W        = 8;
    localparam int CNT_W         = 16;
    localparam int FREE_W        = 18;
    localparam int PAUSE_W       = 3;
    localparam int GRANT_PORTS   = 4;

    localparam logic [PAUSE_W-1:0] PAUSE_RST = 3'd2;
    localparam logic [FREE_W-1:0]  FREE_MAX  = '1;

    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_LOAD    = 2'd1,
        CMD_COMMIT  = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_NOT_READY = 3'd2,
        ST_SHORT     = 3'd3,
        ST_FAULT     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_PICK,
        S_GRANT,
        S_SLOT_OP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_COMMIT,
        OP_RESERVE
    } t_bank_op;

    // one slot record as read from the bank
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  stock;
        logic [CNT_W-1:0]  reserved;
        logic              fault;
    } t_slot;

    // write request to the bank
    typedef struct packed {
        t_bank_op          op;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  stock;
    } t_bank_wr;

    // sequencer controls for the scan unit
    typedef struct packed {
        logic clr_sum;
        logic sum_step;
        logic clr_pick;
        logic pick_step;
    } t_scan_ctl;

endpackage

[rtl/core/lla_slot_bank.sv]
module lla_slot_bank #(
    parameter int NUM_SLOTS = lla_pkg::NUM_SLOTS_DEF,
    parameter int SW        = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SW-1:0]    i_raddr,
    output lla_pkg::t_slot   o_rdata,
    input  logic [SW-1:0]    i_waddr,
    input  lla_pkg::t_bank_wr i_wr
);

    logic [lla_pkg::KIND_W-1:0] r_kind     [NUM_SLOTS];
    logic [lla_pkg::CNT_W-1:0]  r_stock    [NUM_SLOTS];
    logic [lla_pkg::CNT_W-1:0]  r_reserved [NUM_SLOTS];
    logic                       r_fault    [NUM_SLOTS];

    // single read port
    always_comb begin
        o_rdata.kind     = r_kind[i_raddr];
        o_rdata.stock    = r_stock[i_raddr];
        o_rdata.reserved = r_reserved[i_raddr];
        o_rdata.fault    = r_fault[i_raddr];
    end

    // single write port, one operation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_kind[s]     <= '0;
                r_stock[s]    <= '0;
                r_reserved[s] <= '0;
                r_fault[s]    <= 1'b0;
            end
        end else begin
            case (i_wr.op)
                lla_pkg::OP_LOAD: begin
                    r_kind[i_waddr]     <= i_wr.kind;
                    r_stock[i_waddr]    <= i_wr.stock;
                    r_reserved[i_waddr] <= '0;
                    r_fault[i_waddr]    <= 1'b0;
                end
                lla_pkg::OP_COMMIT: begin
                    if (r_stock[i_waddr] != '0 && r_reserved[i_waddr] != '0) begin
                        r_stock[i_waddr]    <= r_stock[i_waddr] - 1'b1;
                        r_reserved[i_waddr] <= r_reserved[i_waddr] - 1'b1;
                    end else begin
                        r_fault[i_waddr] <= 1'b1;
                    end
                end
                lla_pkg::OP_RESERVE: begin
                    r_reserved[i_waddr] <= r_reserved[i_waddr] + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/core/lla_scan.sv]
module lla_scan #(
    parameter int NUM_SLOTS = lla_pkg::NUM_SLOTS_DEF,
    parameter int SW        = 2,
    parameter int FW        = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lla_pkg::t_scan_ctl           i_ctl,
    input  logic [SW-1:0]                i_idx,
    input  lla_pkg::t_slot               i_slot,
    input  logic [lla_pkg::KIND_W-1:0]   i_kind,
    input  logic                         i_pause,
    input  logic [lla_pkg::PAUSE_W-1:0]  i_pause_first,
    output logic [FW-1:0]                o_free,
    output logic                         o_found,
    output logic [SW-1:0]                o_pick
);

    localparam int CW = (SW > lla_pkg::PAUSE_W) ? SW : lla_pkg::PAUSE_W;

    logic                      eligible;
    logic [FW-1:0]             r_free;
    logic                      r_found;
    logic                      r_any_res;
    logic [SW-1:0]             r_min_idx;
    logic [lla_pkg::CNT_W-1:0] r_min_val;
    logic [SW-1:0]             r_max_idx;
    logic [lla_pkg::CNT_W-1:0] r_max_val;

    // eligibility of the slot under the index
    assign eligible = (i_slot.kind == i_kind) && !i_slot.fault
                   && !(i_pause && (CW'(i_idx) >= CW'(i_pause_first)))
                   && (i_slot.stock > i_slot.reserved);

    // free stock accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_sum) begin
            r_free <= '0;
        end else if (i_ctl.sum_step && eligible) begin
            r_free <= r_free + FW'(i_slot.stock - i_slot.reserved);
        end
    end

    // least reserved and most stocked trackers, first index kept on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found   <= 1'b0;
            r_any_res <= 1'b0;
        end else if (i_ctl.clr_pick) begin
            r_found   <= 1'b0;
            r_any_res <= 1'b0;
        end else if (i_ctl.pick_step && eligible) begin
            r_found <= 1'b1;
            if (i_slot.reserved != '0) begin
                r_any_res <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pick_step && eligible) begin
            if (!r_found || i_slot.reserved < r_min_val) begin
                r_min_idx <= i_idx;
                r_min_val <= i_slot.reserved;
            end
            if (!r_found || i_slot.stock > r_max_val) begin
                r_max_idx <= i_idx;
                r_max_val <= i_slot.stock;
            end
        end
    end

    assign o_free  = r_free;
    assign o_found = r_found;
    assign o_pick  = r_any_res ? r_min_idx : r_max_idx;

endmodule

[rtl/core/least_loaded_slot_allocator.sv]
// Least-loaded slot allocator for four supply slots.
// Command channel: an item is taken when start is high and busy is low; the
// command, slot, product type, unit count, hatch and pause inputs are sampled
// at that edge. busy stays high until the result has been shown.
// Result channel: o_strobe is high for exactly one cycle with status, the
// per-slot granted counts and the free total; the receiver cannot stall it.
// Configuration: i_cfg_valid / o_cfg_ready write the pause start slot; ready
// is high while the block is idle.
// Path from the accept edge to the strobe:
//   load, commit: via the slot operation state; unused code, slot out of
//   range, zero count or not ready: straight to the done state
// A request past the checks sums the free stock in one bank scan; each unit
// granted costs a scan of the shared compare unit plus a reservation write.
// busy falls the cycle after the strobe, so one item is in work at a time.
// Reset clears all slot records and sets the pause start to slot 2.
module least_loaded_slot_allocator #(
    parameter int NUM_SLOTS = lla_pkg::NUM_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_slot,
    input  logic [7:0]  i_product_type,
    input  logic [15:0] i_unit_count,
    input  logic        i_hatch_shut,
    input  logic        i_hatch_latched,
    input  logic        i_enable_dispense,
    input  logic        i_pause_upper,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [15:0] o_granted_slot0,
    output logic [15:0] o_granted_slot1,
    output logic [15:0] o_granted_slot2,
    output logic [15:0] o_granted_slot3,
    output logic [17:0] o_free_total
);

    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SUM_W = lla_pkg::CNT_W + SW;
    localparam int FW    = (SUM_W > lla_pkg::FREE_W) ? SUM_W : lla_pkg::FREE_W;
    localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

    lla_pkg::t_state  r_state, n_state;
    lla_pkg::t_cmd    r_cmd, n_cmd;
    lla_pkg::t_status r_status, n_status;

    logic [SW-1:0]                r_idx, n_idx;
    logic [lla_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [lla_pkg::CNT_W-1:0]    r_count, n_count;
    logic [lla_pkg::CNT_W-1:0]    r_left, n_left;
    logic                         r_pause, n_pause;
    logic [lla_pkg::PAUSE_W-1:0]  r_pause_first;
    logic [lla_pkg::FREE_W-1:0]   r_free_total, n_free_total;
    logic [lla_pkg::CNT_W-1:0]    r_granted [lla_pkg::GRANT_PORTS];
    logic [lla_pkg::CNT_W-1:0]    n_granted [lla_pkg::GRANT_PORTS];

    lla_pkg::t_slot     rdata;
    lla_pkg::t_bank_wr  wr;
    logic [SW-1:0]      waddr;
    lla_pkg::t_scan_ctl ctl;
    logic [FW-1:0]      scan_free;
    logic               scan_found;
    logic [SW-1:0]      scan_pick;

    lla_slot_bank #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (r_idx),
        .o_rdata (rdata),
        .i_waddr (waddr),
        .i_wr    (wr)
    );

    lla_scan #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW),
        .FW        (FW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_idx         (r_idx),
        .i_slot        (rdata),
        .i_kind        (r_kind),
        .i_pause       (r_pause),
        .i_pause_first (r_pause_first),
        .o_free        (scan_free),
        .o_found       (scan_found),
        .o_pick        (scan_pick)
    );

    // sequencer: next state, datapath updates and unit controls
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_status     = r_status;
        n_idx        = r_idx;
        n_kind       = r_kind;
        n_count      = r_count;
        n_left       = r_left;
        n_pause      = r_pause;
        n_free_total = r_free_total;
        for (int j = 0; j < lla_pkg::GRANT_PORTS; j++) begin
            n_granted[j] = r_granted[j];
        end
        ctl      = '0;
        wr.op    = lla_pkg::OP_NONE;
        wr.kind  = r_kind;
        wr.stock = r_count;
        waddr    = r_idx;

        case (r_state)
            lla_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd        = lla_pkg::t_cmd'(i_command);
                    n_kind       = i_product_type;
                    n_count      = i_unit_count;
                    n_pause      = i_pause_upper;
                    n_status     = lla_pkg::ST_OK;
                    n_free_total = '0;
                    for (int j = 0; j < lla_pkg::GRANT_PORTS; j++) begin
                        n_granted[j] = '0;
                    end
                    case (lla_pkg::t_cmd'(i_command))
                        lla_pkg::CMD_REQUEST: begin
                            if (i_unit_count == '0) begin
                                n_status = lla_pkg::ST_ZERO;
                                n_state  = lla_pkg::S_DONE;
                            end else if (!(i_hatch_shut && i_hatch_latched
                                           && i_enable_dispense)) begin
                                n_status = lla_pkg::ST_NOT_READY;
                                n_state  = lla_pkg::S_DONE;
                            end else begin
                                n_idx       = '0;
                                ctl.clr_sum = 1'b1;
                                n_state     = lla_pkg::S_SUM;
                            end
                        end
                        lla_pkg::CMD_LOAD, lla_pkg::CMD_COMMIT: begin
                            if (32'(i_slot) < NUM_SLOTS) begin
                                n_idx   = SW'(i_slot);
                                n_state = lla_pkg::S_SLOT_OP;
                            end else begin
                                n_state = lla_pkg::S_DONE;
                            end
                        end
                        default: begin
                            n_state = lla_pkg::S_DONE;
                        end
                    endcase
                end
            end
            // sum free stock over eligible slots, one slot a cycle
            lla_pkg::S_SUM: begin
                ctl.sum_step = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = lla_pkg::S_CHECK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            lla_pkg::S_CHECK: begin
                n_free_total = (scan_free > FW'(lla_pkg::FREE_MAX)) ?
                               lla_pkg::FREE_MAX : scan_free[lla_pkg::FREE_W-1:0];
                if (FW'(r_count) > scan_free) begin
                    n_status = lla_pkg::ST_SHORT;
                    n_state  = lla_pkg::S_DONE;
                end else begin
                    n_left       = r_count;
                    n_idx        = '0;
                    ctl.clr_pick = 1'b1;
                    n_state      = lla_pkg::S_PICK;
                end
            end
            // choose a slot for one unit
            lla_pkg::S_PICK: begin
                ctl.pick_step = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = lla_pkg::S_GRANT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            // reserve the unit on the chosen slot
            lla_pkg::S_GRANT: begin
                if (!scan_found) begin
                    n_state = lla_pkg::S_DONE;
                end else begin
                    wr.op = lla_pkg::OP_RESERVE;
                    waddr = scan_pick;
                    for (int j = 0; j < lla_pkg::GRANT_PORTS; j++) begin
                        if (j < NUM_SLOTS && int'(scan_pick) == j) begin
                            n_granted[j] = r_granted[j] + 1'b1;
                        end
                    end
                    n_left = r_left - 1'b1;
                    if (r_left == lla_pkg::CNT_W'(1)) begin
                        n_state = lla_pkg::S_DONE;
                    end else begin
                        n_idx        = '0;
                        ctl.clr_pick = 1'b1;
                        n_state      = lla_pkg::S_PICK;
                    end
                end
            end
            // load or commit on the addressed slot
            lla_pkg::S_SLOT_OP: begin
                if (r_cmd == lla_pkg::CMD_LOAD) begin
                    wr.op = lla_pkg::OP_LOAD;
                end else begin
                    wr.op = lla_pkg::OP_COMMIT;
                    if (!(rdata.stock != '0 && rdata.reserved != '0)) begin
                        n_status = lla_pkg::ST_FAULT;
                    end
                end
                n_state = lla_pkg::S_DONE;
            end
            lla_pkg::S_DONE: begin
                n_state = lla_pkg::S_IDLE;
            end
            default: begin
                n_state = lla_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_first <= lla_pkg::PAUSE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pause_first <= i_cfg_data;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_kind       <= n_kind;
        r_count      <= n_count;
        r_left       <= n_left;
        r_pause      <= n_pause;
        r_free_total <= n_free_total;
        for (int j = 0; j < lla_pkg::GRANT_PORTS; j++) begin
            r_granted[j] <= n_granted[j];
        end
    end

    assign busy            = (r_state != lla_pkg::S_IDLE);
    assign o_cfg_ready     = (r_state == lla_pkg::S_IDLE);
    assign o_strobe        = (r_state == lla_pkg::S_DONE);
    assign o_status        = r_status;
    assign o_granted_slot0 = r_granted[0];
    assign o_granted_slot1 = r_granted[1];
    assign o_granted_slot2 = r_granted[2];
    assign o_granted_slot3 = r_granted[3];
    assign o_free_total    = r_free_total;

endmodule

[bench/least_loaded_slot_allocator_tb.sv]
`timescale 1ns / 100ps

module least_loaded_slot_allocator_tb;

    localparam int SLOTS       = 4;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 200;
    localparam int BIG_REQUEST = 64;

    // one command item as driven on the input ports
    typedef struct packed {
        lla_pkg::t_cmd cmd;
        logic [1:0]    slot;
        logic [7:0]    kind;
        logic [15:0]   count;
        logic          hatch_shut;
        logic          hatch_latched;
        logic          enable;
        logic          pause;
    } t_order;

    // one result item
    typedef struct packed {
        lla_pkg::t_status  status;
        logic [3:0][15:0]  granted;
        logic [17:0]       free_total;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [1:0]  i_slot;
    logic [7:0]  i_product_type;
    logic [15:0] i_unit_count;
    logic        i_hatch_shut;
    logic        i_hatch_latched;
    logic        i_enable_dispense;
    logic        i_pause_upper;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [15:0] o_granted_slot0;
    logic [15:0] o_granted_slot1;
    logic [15:0] o_granted_slot2;
    logic [15:0] o_granted_slot3;
    logic [17:0] o_free_total;

    // shadow of the slot bank and the pause register
    logic [7:0]  kind_q[SLOTS];
    logic [15:0] stock_q[SLOTS];
    logic [15:0] held_q[SLOTS];
    logic        fault_q[SLOTS];
    logic [2:0]  pause_start;

    t_outcome    outcome_queue[$];
    logic [7:0]  kind_pool[2];
    bit          gaps_on;
    int          fails;
    int unsigned cycle_count;

    least_loaded_slot_allocator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_slot            (i_slot),
        .i_product_type    (i_product_type),
        .i_unit_count      (i_unit_count),
        .i_hatch_shut      (i_hatch_shut),
        .i_hatch_latched   (i_hatch_latched),
        .i_enable_dispense (i_enable_dispense),
        .i_pause_upper     (i_pause_upper),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_granted_slot0   (o_granted_slot0),
        .o_granted_slot1   (o_granted_slot1),
        .o_granted_slot2   (o_granted_slot2),
        .o_granted_slot3   (o_granted_slot3),
        .o_free_total      (o_free_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    // slot takes part in allocation for this kind and pause setting
    function automatic bit slot_open(input int s, input logic [7:0] k, input logic p);
        if (kind_q[s] != k || fault_q[s])
            return 1'b0;
        if (p && s >= pause_start)
            return 1'b0;
        return stock_q[s] > held_q[s];
    endfunction

    function automatic logic [17:0] free_stock(input logic [7:0] k, input logic p);
        logic [17:0] sum;
        sum = '0;
        for (int s = 0; s < SLOTS; s++)
            if (slot_open(s, k, p))
                sum += 18'(stock_q[s] - held_q[s]);
        return sum;
    endfunction

    // least held slot while any open slot holds units, else the fullest; lower wins ties
    function automatic int least_loaded(input logic [7:0] k, input logic p);
        int best;
        bit any_held;
        best     = -1;
        any_held = 1'b0;
        for (int s = 0; s < SLOTS; s++)
            if (slot_open(s, k, p) && held_q[s] != 0)
                any_held = 1'b1;
        for (int s = 0; s < SLOTS; s++) begin
            if (!slot_open(s, k, p))
                continue;
            if (best < 0)
                best = s;
            else if (any_held) begin
                if (held_q[s] < held_q[best])
                    best = s;
            end else if (stock_q[s] > stock_q[best]) begin
                best = s;
            end
        end
        return best;
    endfunction

    // applies one item to the shadow bank and returns its result
    function automatic t_outcome apply_order(input t_order it);
        t_outcome res;
        int       pick;
        res        = '0;
        res.status = lla_pkg::ST_OK;
        case (it.cmd)
            lla_pkg::CMD_REQUEST: begin
                if (it.count == 0) begin
                    res.status = lla_pkg::ST_ZERO;
                end else if (!(it.hatch_shut && it.hatch_latched && it.enable)) begin
                    res.status = lla_pkg::ST_NOT_READY;
                end else begin
                    res.free_total = free_stock(it.kind, it.pause);
                    if (18'(it.count) > res.free_total) begin
                        res.status = lla_pkg::ST_SHORT;
                    end else begin
                        for (int n = 0; n < it.count; n++) begin
                            pick = least_loaded(it.kind, it.pause);
                            if (pick < 0)
                                break;
                            held_q[pick]++;
                            res.granted[pick]++;
                        end
                    end
                end
            end
            lla_pkg::CMD_LOAD: begin
                kind_q[it.slot]  = it.kind;
                stock_q[it.slot] = it.count;
                held_q[it.slot]  = '0;
                fault_q[it.slot] = 1'b0;
            end
            lla_pkg::CMD_COMMIT: begin
                if (stock_q[it.slot] != 0 && held_q[it.slot] != 0) begin
                    stock_q[it.slot]--;
                    held_q[it.slot]--;
                end else begin
                    fault_q[it.slot] = 1'b1;
                    res.status       = lla_pkg::ST_FAULT;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- driving

    function automatic t_order make_order(input lla_pkg::t_cmd c, input logic [1:0] s,
                                          input logic [7:0] k, input logic [15:0] n);
        t_order it;
        it               = '0;
        it.cmd           = c;
        it.slot          = s;
        it.kind          = k;
        it.count         = n;
        it.hatch_shut    = 1'b1;
        it.hatch_latched = 1'b1;
        it.enable        = 1'b1;
        return it;
    endfunction

    // start stays high after acceptance; the next call decides whether to drop it
    task automatic send_item(input t_order it);
        if (gaps_on && $urandom_range(99) < 8) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_command         <= it.cmd;
        i_slot            <= it.slot;
        i_product_type    <= it.kind;
        i_unit_count      <= it.count;
        i_hatch_shut      <= it.hatch_shut;
        i_hatch_latched   <= it.hatch_latched;
        i_enable_dispense <= it.enable;
        i_pause_upper     <= it.pause;
        do @(posedge i_clk); while (busy);
        outcome_queue.push_back(apply_order(it));
    endtask

    // register write, only once the block has drained
    task automatic write_pause_start(input logic [2:0] value);
        start <= 1'b0;
        while (outcome_queue.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        pause_start = value;
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [17:0] want,
                               input logic [17:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            if (outcome_queue.size() == 0) begin
                $error("result item with no request outstanding");
                fails++;
            end else begin
                want = outcome_queue.pop_front();
                check_field("status", 18'(want.status), 18'(o_status));
                check_field("granted_slot0", 18'(want.granted[0]), 18'(o_granted_slot0));
                check_field("granted_slot1", 18'(want.granted[1]), 18'(o_granted_slot1));
                check_field("granted_slot2", 18'(want.granted[2]), 18'(o_granted_slot2));
                check_field("granted_slot3", 18'(want.granted[3]), 18'(o_granted_slot3));
                check_field("free_total", want.free_total, o_free_total);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // loads at the field extremes, commits on empty slots fault them
    task automatic test_slot_commands();
        t_order it;
        send_item(make_order(lla_pkg::CMD_LOAD, 2'd0, 8'h00, 16'hFFFF));
        send_item(make_order(lla_pkg::CMD_LOAD, 2'd3, 8'hFF, 16'h0000));
        send_item(make_order(lla_pkg::CMD_COMMIT, 2'd3, 8'h00, 16'h0000));
        send_item(make_order(lla_pkg::CMD_COMMIT, 2'd1, 8'h00, 16'h0000));
        send_item(make_order(lla_pkg::CMD_LOAD, 2'd1, 8'hFF, 16'd5));
        // unused code carries random fields but changes nothing
        it = make_order(lla_pkg::CMD_NONE, 2'($urandom), 8'($urandom), 16'($urandom));
        send_item(it);
    endtask

    // zero count, each readiness input low, and a request beyond the free stock
    task automatic test_request_checks();
        t_order it;
        send_item(make_order(lla_pkg::CMD_REQUEST, 2'd0, 8'hFF, 16'd0));
        it = make_order(lla_pkg::CMD_REQUEST, 2'd0, 8'hFF, 16'd1);
        it.hatch_shut = 1'b0;
        send_item(it);
        it = make_order(lla_pkg::CMD_REQUEST, 2'd0, 8'hFF, 16'd1);
        it.hatch_latched = 1'b0;
        send_item(it);
        it = make_order(lla_pkg::CMD_REQUEST, 2'd0, 8'hFF, 16'd1);
        it.enable = 1'b0;
        send_item(it);
        send_item(make_order(lla_pkg::CMD_REQUEST, 2'd0, 8'hFF, 16'hFFFF));
    endtask

    // equal stock tie, then least-held spreading, then a paused upper half
    task automatic test_allocation_order();
        t_order it;
        send_item(make_order(lla_pkg::CMD_LOAD, 2'd2, 8'hFF, 16'd9));
        send_item(make_order(lla_pkg::CMD_LOAD, 2'd3, 8'hFF, 16'd9));
        send_item(make_order(lla_pkg::CMD_REQUEST, 2'd0, 8'hFF, 16'd7));
        send_item(make_order(lla_pkg::CMD_COMMIT, 2'd2, 8'h00, 16'd0));
        it = make_order(lla_pkg::CMD_REQUEST, 2'd0, 8'hFF, 16'd3);
        it.pause = 1'b1;
        send_item(it);
        send_item(make_order(lla_pkg::CMD_REQUEST, 2'd0, 8'h00, 16'd40));
    endtask

    // pause start at 0, 1, 4 and 7, including past the last slot
    task automatic test_pause_window();
        logic [2:0] starts[4];
        t_order     it;
        starts = '{3'd0, 3'd4, 3'd7, 3'd1};
        foreach (starts[i]) begin
            write_pause_start(starts[i]);
            it = make_order(lla_pkg::CMD_REQUEST, 2'd0, 8'hFF, 16'd2);
            it.pause = 1'b1;
            send_item(it);
        end
    endtask

    function automatic t_order random_order();
        t_order it;
        int     pick;
        int     held_slots[$];
        pick             = $urandom_range(99);
        it               = '0;
        it.slot          = 2'($urandom_range(3));
        it.kind          = ($urandom_range(9) == 0) ? 8'($urandom) : kind_pool[$urandom_range(1)];
        it.count         = 16'($urandom_range(1, 8));
        it.hatch_shut    = ($urandom_range(19) != 0);
        it.hatch_latched = ($urandom_range(19) != 0);
        it.enable        = ($urandom_range(19) != 0);
        it.pause         = ($urandom_range(9) < 3);
        if (pick < 20) begin
            it.cmd = lla_pkg::CMD_LOAD;
            case ($urandom_range(19))
                0, 1:    it.count = 16'($urandom);
                2:       it.count = 16'hFFFF;
                default: it.count = 16'($urandom_range(0, 40));
            endcase
        end else if (pick < 55) begin
            it.cmd = lla_pkg::CMD_REQUEST;
            case ($urandom_range(9))
                0:       it.count = '0;
                1:       it.count = 16'($urandom);
                default: ;
            endcase
        end else if (pick < 90) begin
            // mostly commit where units are held
            it.cmd = lla_pkg::CMD_COMMIT;
            for (int s = 0; s < SLOTS; s++)
                if (held_q[s] != 0)
                    held_slots.push_back(s);
            if (held_slots.size() != 0 && $urandom_range(9) < 8)
                it.slot = 2'(held_slots[$urandom_range(held_slots.size() - 1)]);
        end else begin
            // noise
            it.cmd   = lla_pkg::t_cmd'(2'($urandom_range(3)));
            it.kind  = 8'($urandom);
            it.count = 16'($urandom);
        end
        // big requests that would succeed cost too many cycles: shrink them
        if (it.cmd == lla_pkg::CMD_REQUEST && it.count > BIG_REQUEST
                && 18'(it.count) <= free_stock(it.kind, it.pause))
            it.count = 16'($urandom_range(1, BIG_REQUEST));
        return it;
    endfunction

    // phases of random traffic, each under its own pause start; one phase runs gap-free
    task automatic test_random_traffic();
        logic [2:0] starts[6];
        starts = '{3'd3, 3'd5, 3'd0, 3'd6, 3'd2, 3'd4};
        foreach (starts[ph]) begin
            write_pause_start(starts[ph]);
            gaps_on = (ph != 2);
            if (ph == 0)
                kind_pool = '{8'h00, 8'hFF};
            else
                kind_pool = '{8'($urandom), 8'($urandom)};
            repeat (PHASE_ITEMS)
                send_item(random_order());
        end
    endtask

    initial begin
        start             <= 1'b0;
        i_rst_n           <= 1'b0;
        i_command         <= lla_pkg::CMD_NONE;
        i_slot            <= '0;
        i_product_type    <= '0;
        i_unit_count      <= '0;
        i_hatch_shut      <= 1'b0;
        i_hatch_latched   <= 1'b0;
        i_enable_dispense <= 1'b0;
        i_pause_upper     <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_data        <= '0;
        cycle_count       = 0;
        fails             = 0;
        gaps_on           = 1'b1;
        pause_start       = lla_pkg::PAUSE_RST;
        for (int s = 0; s < SLOTS; s++) begin
            kind_q[s]  = '0;
            stock_q[s] = '0;
            held_q[s]  = '0;
            fault_q[s] = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_slot_commands();
        test_request_checks();
        test_allocation_order();
        test_pause_window();
        test_random_traffic();

        // drain, then let the block settle
        start <= 1'b0;
        while (outcome_queue.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
